### design/scsa_pkg.sv
// Shared constants and codes for the sparse COO scatter-add block.
`default_nettype none

package scsa_pkg;

  // Parameter defaults
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int MAX_DIMS_DEF    = 4;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int COORD_FIELDS = 4;
  localparam int DIM_IDX_W    = 2;
  localparam int COORD_W      = 12;
  localparam int SIZE_W       = 13;
  localparam int NDIM_W       = 3;
  localparam int FUNC_W       = 2;
  localparam int DATA_W       = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SCATTER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM3 = 3'd5;

endpackage

`default_nettype wire

### design/scsa_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module scsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### design/sparse_coo_scatter_add_top.sv
// Sparse COO scatter-add unit: dense store with load, scatter-add and read transactions.
//
// The block keeps a dense tensor of STORE_DEPTH words in one single-port
// synchronous RAM. Each input transaction is a load (write one entry), a
// scatter-add (entry += alpha * elem_value, wrapping modulo 2^VALUE_WIDTH) or
// a read, addressed by the row-major index built with Horner's rule over the
// num_dims dimensions in use. Every transaction returns exactly one result.
// A used coordinate not below its extent, a linear index not below
// STORE_DEPTH, or the unused func code gives status 1, data 0 and no write.
// Transactions are handled one at a time: the index walk makes one Horner
// step per dimension in use (one shared 13-bit-by-index multiplier), then a
// load or a flagged item finishes in the check state, a read goes through
// RAM issue and the registered read data, and a scatter-add first runs M
// multiplier passes for alpha * value (1 for VALUE_WIDTH up to 32, else 3
// half-width passes) and then the read and the write-back. Each finishing
// step waits while the result register is full and not taken. The block is
// ready again once the result is registered, so it takes no new transaction
// before it is through with the last one.
// The result sits in an output register, so the next transaction is accepted
// while it waits.
// Entries never loaded read back undefined. Configuration writes must be
// issued only while the block is idle.
`default_nettype none

module sparse_coo_scatter_add_top #(
  parameter int STORE_DEPTH = scsa_pkg::STORE_DEPTH_DEF,
  parameter int MAX_DIMS    = scsa_pkg::MAX_DIMS_DEF,
  parameter int VALUE_WIDTH = scsa_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [scsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [scsa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [scsa_pkg::FUNC_W-1:0]         in_func,
  input  wire logic [scsa_pkg::COORD_W-1:0]        in_coord0,
  input  wire logic [scsa_pkg::COORD_W-1:0]        in_coord1,
  input  wire logic [scsa_pkg::COORD_W-1:0]        in_coord2,
  input  wire logic [scsa_pkg::COORD_W-1:0]        in_coord3,
  input  wire logic signed [scsa_pkg::DATA_W-1:0]  in_elem_value,
  input  wire logic                                in_last_item,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [scsa_pkg::DATA_W-1:0]       out_entry_data,
  output logic                                     out_status,
  output logic                                     out_batch_done
);

  localparam int AW      = $clog2(STORE_DEPTH);
  localparam int IW      = AW + scsa_pkg::SIZE_W;          // Horner sum width
  localparam int DIM_LIM = (MAX_DIMS < scsa_pkg::COORD_FIELDS) ?
                           MAX_DIMS : scsa_pkg::COORD_FIELDS;
  // alpha * value: one pass up to 32 bits, else three half-width passes
  localparam int SPLIT   = (VALUE_WIDTH > 32) ? 1 : 0;
  localparam int HW      = (SPLIT != 0) ? (VALUE_WIDTH + 1) / 2 : VALUE_WIDTH;
  localparam int PW      = 2 * HW;
  localparam int NSTEP   = (SPLIT != 0) ? 3 : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX,
    S_CHK,
    S_MUL,
    S_RD,
    S_DATA
  } state_t;

  state_t                                 state_r, state_nxt;

  // configuration
  logic [scsa_pkg::DATA_W-1:0]            alpha_r, alpha_nxt;
  logic [scsa_pkg::NDIM_W-1:0]            num_dims_r, num_dims_nxt;
  logic [scsa_pkg::SIZE_W-1:0]            size_r   [scsa_pkg::COORD_FIELDS];
  logic [scsa_pkg::SIZE_W-1:0]            size_nxt [scsa_pkg::COORD_FIELDS];

  // captured transaction
  logic [scsa_pkg::FUNC_W-1:0]            func_r, func_nxt;
  logic [scsa_pkg::COORD_W-1:0]           coord_r   [scsa_pkg::COORD_FIELDS];
  logic [scsa_pkg::COORD_W-1:0]           coord_nxt [scsa_pkg::COORD_FIELDS];
  logic [VALUE_WIDTH-1:0]                 val_r, val_nxt;
  logic                                   last_r, last_nxt;

  // index walk
  logic [scsa_pkg::DIM_IDX_W-1:0]         d_r, d_nxt;
  logic [scsa_pkg::DIM_IDX_W-1:0]         last_d_r, last_d_nxt;
  logic [AW-1:0]                          acc_r, acc_nxt;
  logic                                   bad_r, bad_nxt;

  // product accumulation
  logic [1:0]                             mstep_r, mstep_nxt;
  logic [VALUE_WIDTH-1:0]                 prod_r, prod_nxt;

  // result register
  logic                                   out_valid_r, out_valid_nxt;
  logic [scsa_pkg::DATA_W-1:0]            out_data_r, out_data_nxt;
  logic                                   out_status_r, out_status_nxt;
  logic                                   out_done_r, out_done_nxt;

  // RAM port
  logic                                   ram_en;
  logic                                   ram_we;
  logic [VALUE_WIDTH-1:0]                 ram_wdata;
  logic [VALUE_WIDTH-1:0]                 ram_rdata;

  // datapath helpers
  logic                                   in_fire;
  logic                                   slot_free;
  logic                                   fin;
  logic [scsa_pkg::NDIM_W-1:0]            n_eff;
  logic                                   coord_bad;
  logic [IW-1:0]                          idx_sum;
  logic                                   idx_over;
  logic [VALUE_WIDTH-1:0]                 alpha_w;
  logic [PW-1:0]                          a_pad, v_pad;
  logic [HW-1:0]                          op_a, op_b;
  logic [PW-1:0]                          pp;
  logic [PW-1:0]                          pp_shift;
  logic [VALUE_WIDTH-1:0]                 sum_w;

  scsa_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (acc_r),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // effective dimension count: 0 acts as 1, saturate at the limit
  always_comb begin
    if (num_dims_r == '0) begin
      n_eff = scsa_pkg::NDIM_W'(1);
    end else if (num_dims_r > scsa_pkg::NDIM_W'(DIM_LIM)) begin
      n_eff = scsa_pkg::NDIM_W'(DIM_LIM);
    end else begin
      n_eff = num_dims_r;
    end
  end

  // one Horner step per cycle
  assign coord_bad = {1'b0, coord_r[d_r]} >= size_r[d_r];
  assign idx_sum   = IW'(acc_r) * IW'(size_r[d_r]) + IW'(coord_r[d_r]);
  assign idx_over  = idx_sum >= IW'(STORE_DEPTH);

  // alpha * value modulo 2^VALUE_WIDTH, partial products on one multiplier
  assign alpha_w = VALUE_WIDTH'(signed'(alpha_r));
  assign a_pad   = PW'(alpha_w);
  assign v_pad   = PW'(val_r);

  always_comb begin
    case (mstep_r)
      2'd1:    begin op_a = a_pad[HW-1:0];  op_b = v_pad[PW-1:HW]; end
      2'd2:    begin op_a = a_pad[PW-1:HW]; op_b = v_pad[HW-1:0];  end
      default: begin op_a = a_pad[HW-1:0];  op_b = v_pad[HW-1:0];  end
    endcase
  end

  assign pp       = PW'(op_a) * PW'(op_b);
  assign pp_shift = (mstep_r == 2'd0) ? pp : (pp << HW);
  assign sum_w    = ram_rdata + prod_r;

  always_comb begin
    state_nxt      = state_r;
    alpha_nxt      = alpha_r;
    num_dims_nxt   = num_dims_r;
    size_nxt       = size_r;
    func_nxt       = func_r;
    coord_nxt      = coord_r;
    val_nxt        = val_r;
    last_nxt       = last_r;
    d_nxt          = d_r;
    last_d_nxt     = last_d_r;
    acc_nxt        = acc_r;
    bad_nxt        = bad_r;
    mstep_nxt      = mstep_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_done_nxt   = out_done_r;
    in_ready       = 1'b0;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_wdata      = val_r;
    fin            = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        scsa_pkg::REG_ALPHA:     alpha_nxt    = cfg_wdata;
        scsa_pkg::REG_NUM_DIMS:  num_dims_nxt = cfg_wdata[scsa_pkg::NDIM_W-1:0];
        scsa_pkg::REG_SIZE_DIM0: size_nxt[0]  = cfg_wdata[scsa_pkg::SIZE_W-1:0];
        scsa_pkg::REG_SIZE_DIM1: size_nxt[1]  = cfg_wdata[scsa_pkg::SIZE_W-1:0];
        scsa_pkg::REG_SIZE_DIM2: size_nxt[2]  = cfg_wdata[scsa_pkg::SIZE_W-1:0];
        scsa_pkg::REG_SIZE_DIM3: size_nxt[3]  = cfg_wdata[scsa_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt     = in_func;
          coord_nxt[0] = in_coord0;
          coord_nxt[1] = in_coord1;
          coord_nxt[2] = in_coord2;
          coord_nxt[3] = in_coord3;
          val_nxt      = VALUE_WIDTH'(in_elem_value);
          last_nxt     = in_last_item;
          d_nxt        = '0;
          last_d_nxt   = scsa_pkg::DIM_IDX_W'(n_eff - scsa_pkg::NDIM_W'(1));
          acc_nxt      = '0;
          bad_nxt      = 1'b0;
          mstep_nxt    = '0;
          prod_nxt     = '0;
          state_nxt    = S_IDX;
        end
      end

      S_IDX: begin
        acc_nxt = idx_sum[AW-1:0];
        bad_nxt = bad_r || coord_bad || idx_over;
        if (d_r == last_d_r) begin
          state_nxt = S_CHK;
        end else begin
          d_nxt = d_r + scsa_pkg::DIM_IDX_W'(1);
        end
      end

      S_CHK: begin
        if (bad_r || func_r == scsa_pkg::FUNC_UNUSED) begin
          if (slot_free) begin
            fin            = 1'b1;
            out_data_nxt   = '0;
            out_status_nxt = 1'b1;
            out_done_nxt   = (func_r == scsa_pkg::FUNC_SCATTER) && last_r;
            state_nxt      = S_IDLE;
          end
        end else if (func_r == scsa_pkg::FUNC_LOAD) begin
          if (slot_free) begin
            fin            = 1'b1;
            ram_en         = 1'b1;
            ram_we         = 1'b1;
            ram_wdata      = val_r;
            out_data_nxt   = scsa_pkg::DATA_W'(val_r);
            out_status_nxt = 1'b0;
            out_done_nxt   = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else if (func_r == scsa_pkg::FUNC_SCATTER) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_RD;
        end
      end

      S_MUL: begin
        prod_nxt = prod_r + pp_shift[VALUE_WIDTH-1:0];
        if (mstep_r == 2'(NSTEP - 1)) begin
          state_nxt = S_RD;
        end else begin
          mstep_nxt = mstep_r + 2'd1;
        end
      end

      S_RD: begin
        ram_en    = 1'b1;
        state_nxt = S_DATA;
      end

      S_DATA: begin
        if (slot_free) begin
          fin            = 1'b1;
          out_status_nxt = 1'b0;
          state_nxt      = S_IDLE;
          if (func_r == scsa_pkg::FUNC_SCATTER) begin
            ram_en       = 1'b1;
            ram_we       = 1'b1;
            ram_wdata    = sum_w;
            out_data_nxt = scsa_pkg::DATA_W'(sum_w);
            out_done_nxt = last_r;
          end else begin
            out_data_nxt = scsa_pkg::DATA_W'(ram_rdata);
            out_done_nxt = 1'b0;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      alpha_r     <= scsa_pkg::DATA_W'(1);
      num_dims_r  <= scsa_pkg::NDIM_W'(1);
      for (int i = 0; i < scsa_pkg::COORD_FIELDS; i++) begin
        size_r[i] <= scsa_pkg::SIZE_W'(1);
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      alpha_r     <= alpha_nxt;
      num_dims_r  <= num_dims_nxt;
      size_r      <= size_nxt;
    end
    func_r       <= func_nxt;
    coord_r      <= coord_nxt;
    val_r        <= val_nxt;
    last_r       <= last_nxt;
    d_r          <= d_nxt;
    last_d_r     <= last_d_nxt;
    acc_r        <= acc_nxt;
    bad_r        <= bad_nxt;
    mstep_r      <= mstep_nxt;
    prod_r       <= prod_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_entry_data = out_data_r;
  assign out_status     = out_status_r;
  assign out_batch_done = out_done_r;

  // flagged transactions never touch the store
  a_no_write_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !bad_r)
    else $error("store written for an out-of-range transaction");

  // batch_done only closes a scatter batch
  a_done_on_scatter: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && out_done_nxt) |-> (func_r == scsa_pkg::FUNC_SCATTER) && last_r)
    else $error("batch_done raised outside a final scatter transaction");

  // a flagged result carries zero data
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_data_r == '0))
    else $error("flagged result carries nonzero data");

  // every accepted transaction starts its index walk at dimension zero
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_IDX) && (d_r == '0) && !bad_r)
    else $error("index walk did not start cleanly");

  // the RAM is only driven once the index walk is done
  a_ram_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ram_en |-> (state_r == S_CHK) || (state_r == S_RD) || (state_r == S_DATA))
    else $error("store accessed during index walk");

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the sparse COO scatter-add block.
`timescale 1ns / 1ps

module tb_top;

  // Store size and dimension limit of the default build
  localparam int STORE_DEPTH   = scsa_pkg::STORE_DEPTH_DEF;
  localparam int MAX_DIMS      = scsa_pkg::MAX_DIMS_DEF;
  // Idle cycles after the last result before registers are touched
  localparam int SETTLE_CYCLES = 16;
  localparam int HOT_SLOTS     = 8;

  // One input transaction as it goes over the input channel
  typedef struct packed {
    logic [scsa_pkg::FUNC_W-1:0]                              func;
    logic [scsa_pkg::COORD_FIELDS-1:0][scsa_pkg::COORD_W-1:0] crd;
    logic [scsa_pkg::DATA_W-1:0]                              val;
    logic                                                     last;
  } coo_item_t;

  // One result transaction
  typedef struct packed {
    logic [scsa_pkg::DATA_W-1:0] data;
    logic                        status;
    logic                        done;
  } entry_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 cfg_we;
  logic [scsa_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [scsa_pkg::CFG_DATA_W-1:0]      cfg_wdata;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [scsa_pkg::FUNC_W-1:0]          in_func;
  logic [scsa_pkg::COORD_W-1:0]         in_coord0;
  logic [scsa_pkg::COORD_W-1:0]         in_coord1;
  logic [scsa_pkg::COORD_W-1:0]         in_coord2;
  logic [scsa_pkg::COORD_W-1:0]         in_coord3;
  logic signed [scsa_pkg::DATA_W-1:0]   in_elem_value;
  logic                                 in_last_item;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [scsa_pkg::DATA_W-1:0]   out_entry_data;
  logic                                 out_status;
  logic                                 out_batch_done;

  // Mirror of the block: dense store, which entries hold loaded data, registers
  logic [scsa_pkg::DATA_W-1:0]          dense_mirror [STORE_DEPTH];
  bit                                   loaded_map   [STORE_DEPTH];
  logic [scsa_pkg::DATA_W-1:0]          alpha_q;
  logic [scsa_pkg::NDIM_W-1:0]          ndims_q;
  logic [scsa_pkg::SIZE_W-1:0]          size_q [scsa_pkg::COORD_FIELDS];

  // Results still owed by the block, oldest first
  entry_result_t                        pending_entries[$];

  // Recently used coordinates, reused to hit the same entry back to back
  logic [scsa_pkg::COORD_FIELDS-1:0][scsa_pkg::COORD_W-1:0] recent_crd [HOT_SLOTS];
  int                                   recent_ptr = 0;

  // Idle percentages of sender and receiver
  int                                   send_idle_pct = 0;
  int                                   recv_idle_pct = 0;

  int                                   err_count  = 0;
  int                                   n_load     = 0;
  int                                   n_scatter  = 0;
  int                                   n_read     = 0;
  int                                   n_unused   = 0;
  int                                   n_flagged  = 0;
  int                                   n_batches  = 0;
  int                                   n_settings = 0;

  sparse_coo_scatter_add_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_coord0      (in_coord0),
    .in_coord1      (in_coord1),
    .in_coord2      (in_coord2),
    .in_coord3      (in_coord3),
    .in_elem_value  (in_elem_value),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_entry_data (out_entry_data),
    .out_status     (out_status),
    .out_batch_done (out_batch_done)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure: one decision per cycle, changed at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Row-major linear index by Horner's rule over the dimensions in use.
  // Returns 0 when a used coordinate is not below its extent or the index
  // falls outside the store. A zero dimension count means one; counts above
  // the supported maximum are clipped.
  function automatic bit find_entry(
      input logic [scsa_pkg::COORD_FIELDS-1:0][scsa_pkg::COORD_W-1:0] crd,
      output int unsigned lin);
    int                n;
    longint unsigned   acc;
    n   = ndims_q;
    acc = 0;
    lin = 0;
    if (n == 0) n = 1;
    if (n > MAX_DIMS) n = MAX_DIMS;
    if (n > scsa_pkg::COORD_FIELDS) n = scsa_pkg::COORD_FIELDS;
    for (int d = 0; d < n; d++) begin
      if (crd[d] >= size_q[d]) return 1'b0;
      acc = acc * size_q[d] + crd[d];
    end
    if (acc >= STORE_DEPTH) return 1'b0;
    lin = 32'(acc);
    return 1'b1;
  endfunction

  // Applies one accepted transaction to the mirror and returns the result it
  // must produce. Products and sums wrap at 32 bits.
  function automatic entry_result_t entry_result(input coo_item_t it);
    entry_result_t r;
    int unsigned   lin;
    r = '0;
    if (it.func == scsa_pkg::FUNC_UNUSED) begin
      r.status = 1'b1;
    end else begin
      // a flagged scatter-add still closes its batch
      if (it.func == scsa_pkg::FUNC_SCATTER) r.done = it.last;
      if (!find_entry(it.crd, lin)) begin
        r.status = 1'b1;
      end else begin
        case (it.func)
          scsa_pkg::FUNC_LOAD: begin
            dense_mirror[lin] = it.val;
            loaded_map[lin]   = 1'b1;
          end
          scsa_pkg::FUNC_SCATTER: begin
            dense_mirror[lin] = dense_mirror[lin] + alpha_q * it.val;
          end
          default: ;
        endcase
        r.data = dense_mirror[lin];
      end
    end
    return r;
  endfunction

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    entry_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected result data=%h status=%b done=%b", $time,
                 out_entry_data, out_status, out_batch_done);
        err_count++;
      end else begin
        want = pending_entries.pop_front();
        if (out_entry_data !== want.data) begin
          $display("%0t: entry_data mismatch: expected %h, actual %h", $time,
                   want.data, out_entry_data);
          err_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %b, actual %b", $time,
                   want.status, out_status);
          err_count++;
        end
        if (out_batch_done !== want.done) begin
          $display("%0t: batch_done mismatch: expected %b, actual %b", $time,
                   want.done, out_batch_done);
          err_count++;
        end
        n_flagged += want.status;
        n_batches += want.done;
      end
    end
  end

  // Drive one transaction at the falling edge, idling first at random, and
  // return at the rising edge that accepts it.
  task automatic send_item(input coo_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= it.func;
    in_coord0     <= it.crd[0];
    in_coord1     <= it.crd[1];
    in_coord2     <= it.crd[2];
    in_coord3     <= it.crd[3];
    in_elem_value <= it.val;
    in_last_item  <= it.last;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_entries.push_back(entry_result(it));
    recent_crd[recent_ptr] = it.crd;
    recent_ptr = (recent_ptr + 1) % HOT_SLOTS;
    case (it.func)
      scsa_pkg::FUNC_LOAD:    n_load++;
      scsa_pkg::FUNC_SCATTER: n_scatter++;
      scsa_pkg::FUNC_READ:    n_read++;
      default:                n_unused++;
    endcase
  endtask

  task automatic issue(input logic [scsa_pkg::FUNC_W-1:0] func,
                       input logic [scsa_pkg::COORD_W-1:0] c0,
                       input logic [scsa_pkg::COORD_W-1:0] c1,
                       input logic [scsa_pkg::COORD_W-1:0] c2,
                       input logic [scsa_pkg::COORD_W-1:0] c3,
                       input logic [scsa_pkg::DATA_W-1:0] val,
                       input logic last);
    coo_item_t it;
    it.func = func;
    it.crd  = {c3, c2, c1, c0};
    it.val  = val;
    it.last = last;
    send_item(it);
  endtask

  // Stop sending and wait until every owed result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [scsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scsa_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      scsa_pkg::REG_ALPHA:     alpha_q   = data;
      scsa_pkg::REG_NUM_DIMS:  ndims_q   = data[scsa_pkg::NDIM_W-1:0];
      scsa_pkg::REG_SIZE_DIM0: size_q[0] = data[scsa_pkg::SIZE_W-1:0];
      scsa_pkg::REG_SIZE_DIM1: size_q[1] = data[scsa_pkg::SIZE_W-1:0];
      scsa_pkg::REG_SIZE_DIM2: size_q[2] = data[scsa_pkg::SIZE_W-1:0];
      scsa_pkg::REG_SIZE_DIM3: size_q[3] = data[scsa_pkg::SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // Field value with random junk above the register width half of the time
  function automatic logic [scsa_pkg::CFG_DATA_W-1:0] with_noise(
      input logic [scsa_pkg::CFG_DATA_W-1:0] v, input int w);
    logic [scsa_pkg::CFG_DATA_W-1:0] m;
    m = (32'h1 << w) - 1;
    return ($urandom_range(0, 1) ? ($urandom & ~m) : '0) | (v & m);
  endfunction

  // New tensor shape and scale, written only once the block has gone idle
  task automatic set_shape(input int nd, input int s0, input int s1, input int s2,
                           input int s3, input logic [scsa_pkg::DATA_W-1:0] alpha);
    wait_idle();
    write_reg(scsa_pkg::REG_ALPHA, alpha);
    write_reg(scsa_pkg::REG_NUM_DIMS, with_noise(nd, scsa_pkg::NDIM_W));
    write_reg(scsa_pkg::REG_SIZE_DIM0, with_noise(s0, scsa_pkg::SIZE_W));
    write_reg(scsa_pkg::REG_SIZE_DIM1, with_noise(s1, scsa_pkg::SIZE_W));
    write_reg(scsa_pkg::REG_SIZE_DIM2, with_noise(s2, scsa_pkg::SIZE_W));
    write_reg(scsa_pkg::REG_SIZE_DIM3, with_noise(s3, scsa_pkg::SIZE_W));
    n_settings++;
  endtask

  function automatic logic [scsa_pkg::DATA_W-1:0] pick_alpha();
    case ($urandom_range(0, 7))
      0:       return 32'h1;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0;
      5:       return $urandom_range(2, 9);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [scsa_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 15);
      3:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Random transaction for the current shape. Coordinates mostly fall inside
  // the extents; now and then they are raw 12-bit noise. Scatter-adds and
  // reads often revisit a recent entry. A scatter-add or read that would hit
  // an entry never loaded becomes a load instead.
  function automatic coo_item_t make_item();
    coo_item_t   it;
    int unsigned lin;
    int          cap;
    int          kind;
    kind = $urandom_range(0, 99);
    if (kind < 25)      it.func = scsa_pkg::FUNC_LOAD;
    else if (kind < 70) it.func = scsa_pkg::FUNC_SCATTER;
    else if (kind < 96) it.func = scsa_pkg::FUNC_READ;
    else                it.func = scsa_pkg::FUNC_UNUSED;
    for (int d = 0; d < scsa_pkg::COORD_FIELDS; d++) begin
      cap = (size_q[d] > 4096) ? 4096 : size_q[d];
      if (cap == 0 || $urandom_range(0, 15) == 0)
        it.crd[d] = scsa_pkg::COORD_W'($urandom_range(0, 4095));
      else
        it.crd[d] = scsa_pkg::COORD_W'($urandom_range(0, cap - 1));
    end
    if ((it.func == scsa_pkg::FUNC_SCATTER || it.func == scsa_pkg::FUNC_READ) &&
        $urandom_range(0, 1))
      it.crd = recent_crd[$urandom_range(0, HOT_SLOTS - 1)];
    it.val  = pick_value();
    it.last = (it.func == scsa_pkg::FUNC_SCATTER) ? ($urandom_range(0, 7) == 0) :
              1'($urandom_range(0, 1));
    if ((it.func == scsa_pkg::FUNC_SCATTER || it.func == scsa_pkg::FUNC_READ) &&
        find_entry(it.crd, lin))
      if (!loaded_map[lin]) it.func = scsa_pkg::FUNC_LOAD;
    return it;
  endfunction

  // Reset register values: one dimension of extent one, scale one
  task automatic test_reset_state();
    issue(scsa_pkg::FUNC_LOAD,    12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 1'b1);
    issue(scsa_pkg::FUNC_SCATTER, 12'd0, 12'd0,   12'd0,   12'd0,   32'h1,         1'b1);
    issue(scsa_pkg::FUNC_READ,    12'd0, 12'hFFF, 12'd0,   12'hFFF, 32'h0,         1'b0);
    issue(scsa_pkg::FUNC_LOAD,    12'd1, 12'd0,   12'd0,   12'd0,   32'h5,         1'b0);
    issue(scsa_pkg::FUNC_UNUSED,  12'd0, 12'd0,   12'd0,   12'd0,   32'hFFFF_FFFF, 1'b1);
  endtask

  // Four dimensions (count above the maximum saturates), extreme scale and data
  task automatic test_value_extremes();
    set_shape(7, 8, 8, 8, 8, 32'h8000_0000);
    issue(scsa_pkg::FUNC_LOAD,    12'd7, 12'd7, 12'd7, 12'd7, 32'h8000_0000, 1'b0);
    issue(scsa_pkg::FUNC_SCATTER, 12'd7, 12'd7, 12'd7, 12'd7, 32'hFFFF_FFFF, 1'b0);
    issue(scsa_pkg::FUNC_LOAD,    12'd0, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 1'b0);
    issue(scsa_pkg::FUNC_SCATTER, 12'd0, 12'd0, 12'd0, 12'd0, 32'h7FFF_FFFF, 1'b0);
    issue(scsa_pkg::FUNC_READ,    12'd0, 12'd0, 12'd0, 12'd0, 32'h0,         1'b1);
    // flagged scatter-add still ends the batch
    issue(scsa_pkg::FUNC_SCATTER, 12'd0, 12'd0, 12'd0, 12'd8, 32'h1,         1'b1);
    issue(scsa_pkg::FUNC_READ,    12'd8, 12'd0, 12'd0, 12'd0, 32'h0,         1'b0);
    issue(scsa_pkg::FUNC_LOAD,    12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'h1234_5678, 1'b0);
  endtask

  // Zero dimension count acts as one; index past the store with in-range coordinates
  task automatic test_dim_handling();
    set_shape(0, 8191, 1, 1, 1, 32'hFFFF_FFFF);
    issue(scsa_pkg::FUNC_LOAD,    12'hFFF, 12'd5, 12'd9, 12'd1, 32'h5, 1'b0);
    issue(scsa_pkg::FUNC_SCATTER, 12'hFFF, 12'd0, 12'd0, 12'd0, 32'h5, 1'b1);
    issue(scsa_pkg::FUNC_READ,    12'hFFF, 12'd3, 12'd0, 12'd0, 32'h0, 1'b0);
    set_shape(2, 100, 100, 8191, 0, 32'h7FFF_FFFF);
    issue(scsa_pkg::FUNC_LOAD,    12'd40, 12'd95, 12'd0, 12'd0, 32'hCAFE_0001, 1'b0);
    issue(scsa_pkg::FUNC_LOAD,    12'd40, 12'd96, 12'd0, 12'd0, 32'hCAFE_0002, 1'b0);
    issue(scsa_pkg::FUNC_SCATTER, 12'd99, 12'd99, 12'd0, 12'd0, 32'h3,         1'b1);
  endtask

  // A zero extent in a used dimension flags every transaction
  task automatic test_range_flags();
    set_shape(2, 64, 0, 1, 1, 32'h0);
    issue(scsa_pkg::FUNC_READ,    12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0);
    issue(scsa_pkg::FUNC_LOAD,    12'd0, 12'd0, 12'd0, 12'd0, 32'h9, 1'b0);
    issue(scsa_pkg::FUNC_SCATTER, 12'd0, 12'd0, 12'd0, 12'd0, 32'h9, 1'b1);
  endtask

  // Random traffic over a fixed set of shapes, with the given idle rates.
  // Now and then the sender holds off until the block has drained.
  task automatic test_random_stream(input int sidle, input int ridle, input int n_items);
    int per_shape;
    per_shape = n_items / 7;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int shape = 0; shape < 7; shape++) begin
      case (shape)
        0: set_shape(1, 4096, 1, 1, 1, pick_alpha());
        1: set_shape(2, 64, 64, 1, 1, pick_alpha());
        2: set_shape(3, 16, 16, 16, 1, pick_alpha());
        3: set_shape(4, 8, 8, 8, 8, pick_alpha());
        4: set_shape(2, 100, 50, 1, 1, pick_alpha());  // part of the index range overflows
        5: set_shape(3, $urandom_range(1, 20), $urandom_range(1, 20),
                     $urandom_range(1, 20), $urandom_range(1, 20), pick_alpha());
        default: set_shape($urandom_range(0, 7),
                           ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24),
                           ($urandom_range(0, 4) == 0) ? 8191 : $urandom_range(1, 24),
                           $urandom_range(1, 24), $urandom_range(1, 24), pick_alpha());
      endcase
      for (int k = 0; k < per_shape; k++) begin
        if ($urandom_range(0, 63) == 0) wait_idle();
        send_item(make_item());
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_func       = scsa_pkg::FUNC_LOAD;
    in_coord0     = '0;
    in_coord1     = '0;
    in_coord2     = '0;
    in_coord3     = '0;
    in_elem_value = '0;
    in_last_item  = 1'b0;
    alpha_q       = 32'h1;
    ndims_q       = 3'd1;
    for (int d = 0; d < scsa_pkg::COORD_FIELDS; d++) size_q[d] = 13'd1;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      dense_mirror[i] = '0;
      loaded_map[i]   = 1'b0;
    end
    for (int i = 0; i < HOT_SLOTS; i++) recent_crd[i] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_value_extremes();
    test_dim_handling();
    test_range_flags();
    test_random_stream(21, 67, 700);
    test_random_stream(67, 21, 700);
    test_random_stream(0, 0, 700);
    wait_idle();

    $display("Covered %0d loads, %0d scatter-adds, %0d reads, %0d unused-op transactions;",
             n_load, n_scatter, n_read, n_unused);
    $display("%0d results flagged out of range, %0d batch ends, %0d register settings.",
             n_flagged, n_batches, n_settings);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", pending_entries.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
